// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_ALWAYS(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: property violated");

// Check that a condition on one edge brings a consequence on the next edge.
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: property violated");

`endif

// File: design/ipv_pkg.sv
// ----------------------------------------------------------------------------
// ipv_pkg
// Shared beat types, character codes and character classes for the
// address text validator.
// ----------------------------------------------------------------------------
package ipv_pkg;

  // Input beat: one byte of the text and the end-of-string mark
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } ipv_in_t;

  // Result beat
  typedef struct packed {
    logic is_ipv4;
    logic is_ipv6;
  } ipv_out_t;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // Space, TAB, LF, VT, FF, CR
  function automatic logic is_white(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == ChPlus) || (c == ChMinus);
  endfunction

endpackage

// File: design/ipv_dot_check.sv
// ----------------------------------------------------------------------------
// ipv_dot_check
// Dotted IPv4 parse state. Updates once per byte and reports the verdict
// combinationally for the final byte of a string.
// ----------------------------------------------------------------------------
module ipv_dot_check import ipv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] char_i,
  input  logic       last_i,
  output logic       ok_o
);

  typedef enum logic [1:0] {
    PhSpace,
    PhSign,
    PhDigit
  } phase_e;

  localparam logic [7:0] ChDot = 8'h2E;

  logic       fail_q, fail_d, b_fail, e_fail;
  logic [1:0] parts_q, parts_d, b_parts;
  phase_e     phase_q, phase_d, b_phase;
  logic [8:0] value_q, value_d, b_value;
  logic       neg_q, neg_d, b_neg;
  logic [3:0] digit;
  logic [11:0] prod;

  // A part is bad unless it ended in digits, is not a nonzero negative, and fits
  function automatic logic part_bad(input phase_e ph, input logic neg,
                                    input logic [8:0] val);
    return (ph != PhDigit) || (neg && (val != 9'd0)) || (val > 9'd255);
  endfunction

  assign digit = 4'(char_i - ChZero);
  assign prod  = {value_q, 3'b000} + {2'b00, value_q, 1'b0} + {8'd0, digit};

  // Apply one byte
  always_comb begin
    b_fail  = fail_q;
    b_parts = parts_q;
    b_phase = phase_q;
    b_value = value_q;
    b_neg   = neg_q;
    if (char_i == ChNul) begin
      b_fail = 1'b1;
    end else if (char_i == ChDot) begin
      if (last_i || part_bad(phase_q, neg_q, value_q) || (parts_q == 2'd3)) begin
        b_fail = 1'b1;
      end
      if (parts_q != 2'd3) begin
        b_parts = parts_q + 2'd1;
      end
      b_phase = PhSpace;
      b_value = '0;
      b_neg   = 1'b0;
    end else if (is_digit(char_i)) begin
      b_value = (prod > 12'd255) ? 9'd256 : prod[8:0];
      b_phase = PhDigit;
    end else if ((phase_q == PhSpace) && is_white(char_i)) begin
      b_phase = PhSpace;
    end else if ((phase_q == PhSpace) && is_sign(char_i)) begin
      b_neg   = (char_i == ChMinus);
      b_phase = PhSign;
    end else begin
      b_fail = 1'b1;
    end
  end

  // Close the final part
  assign e_fail = b_fail || part_bad(b_phase, b_neg, b_value);
  assign ok_o   = !e_fail;

  // Advance on each byte, clear after the final one
  always_comb begin
    fail_d  = fail_q;
    parts_d = parts_q;
    phase_d = phase_q;
    value_d = value_q;
    neg_d   = neg_q;
    if (step_i && last_i) begin
      fail_d  = 1'b0;
      parts_d = '0;
      phase_d = PhSpace;
      value_d = '0;
      neg_d   = 1'b0;
    end else if (step_i) begin
      fail_d  = b_fail;
      parts_d = b_parts;
      phase_d = b_phase;
      value_d = b_value;
      neg_d   = b_neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_q  <= 1'b0;
      parts_q <= '0;
      phase_q <= PhSpace;
      value_q <= '0;
      neg_q   <= 1'b0;
    end else begin
      fail_q  <= fail_d;
      parts_q <= parts_d;
      phase_q <= phase_d;
      value_q <= value_d;
      neg_q   <= neg_d;
    end
  end

endmodule

// File: design/ipv_colon_check.sv
// ----------------------------------------------------------------------------
// ipv_colon_check
// Colon IPv6 parse state with gap tracking, byte count and previous byte.
// Reports the verdict combinationally for the final byte of a string.
// ----------------------------------------------------------------------------
module ipv_colon_check import ipv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] char_i,
  input  logic       last_i,
  output logic       ok_o
);

  typedef enum logic [2:0] {
    PhEmpty,
    PhSpace,
    PhSign,
    PhZero,
    PhPrefix,
    PhHex
  } phase_e;

  typedef struct packed {
    logic       fail;
    logic       gap;
    logic [3:0] parts;
  } part_t;

  localparam logic [7:0]  ChColon   = 8'h3A;
  localparam logic [7:0]  ChLowX    = 8'h78;
  localparam logic [7:0]  ChUpX     = 8'h58;
  localparam logic [7:0]  ChLowA    = 8'h61;
  localparam logic [7:0]  ChLowF    = 8'h66;
  localparam logic [7:0]  ChUpA     = 8'h41;
  localparam logic [7:0]  ChUpF     = 8'h46;
  localparam logic [3:0]  FullParts = 4'd8;
  localparam logic [16:0] MaxValue  = 17'h0FFFF;
  localparam logic [16:0] SatValue  = 17'h10000;

  logic        seen;
  logic [1:0]  count_q, count_d;
  logic [7:0]  prev_q, prev_d;
  logic        fail_q, fail_d;
  logic        gap_q, gap_d;
  logic [3:0]  parts_q, parts_d;
  phase_e      phase_q, phase_d, b_phase;
  logic [16:0] value_q, value_d, b_value;
  logic        neg_q, neg_d, b_neg;
  part_t       cur, b_part, e_part;
  logic        hex_ok;
  logic [3:0]  hex_v;
  logic [20:0] hex_acc;
  logic        lead_gap, f_fail;

  assign seen = (count_q != 2'd0);

  // Hex digit decode
  always_comb begin
    hex_ok = 1'b1;
    hex_v  = '0;
    if (is_digit(char_i)) begin
      hex_v = 4'(char_i - ChZero);
    end else if ((char_i >= ChLowA) && (char_i <= ChLowF)) begin
      hex_v = 4'(char_i - ChLowA + 8'd10);
    end else if ((char_i >= ChUpA) && (char_i <= ChUpF)) begin
      hex_v = 4'(char_i - ChUpA + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign hex_acc = {value_q, 4'b0000} + {17'd0, hex_v};

  // Close a part: an empty part opens the gap, a numeric part must fit
  function automatic part_t end_part(input part_t p, input phase_e ph,
                                     input logic neg, input logic [16:0] val);
    part_t r;
    r = p;
    if (ph == PhEmpty) begin
      if (p.gap) r.fail = 1'b1;
      r.gap = 1'b1;
    end else if ((ph == PhZero) || (ph == PhHex)) begin
      if (!neg && (val > MaxValue)) r.fail = 1'b1;
    end else begin
      r.fail = 1'b1;
    end
    if (p.parts != 4'd15) r.parts = p.parts + 4'd1;
    return r;
  endfunction

  assign cur      = '{fail: fail_q, gap: gap_q, parts: parts_q};
  assign lead_gap = (count_q == 2'd1) && (prev_q == ChColon);

  // Apply one byte
  always_comb begin
    b_part  = cur;
    b_phase = phase_q;
    b_value = value_q;
    b_neg   = neg_q;
    if (last_i && !seen) begin
      b_part.fail = 1'b1;
    end
    if (last_i && (char_i == ChColon) && (prev_q != ChColon)) begin
      b_part.fail = 1'b1;
    end
    if (char_i == ChNul) begin
      b_part.fail = 1'b1;
    end else if (char_i == ChColon) begin
      if (lead_gap) begin
        b_part.gap   = 1'b1;
        b_part.parts = '0;
      end else begin
        b_part = end_part(b_part, phase_q, neg_q, value_q);
      end
      b_phase = PhEmpty;
      b_value = '0;
      b_neg   = 1'b0;
    end else begin
      case (phase_q)
        PhEmpty, PhSpace, PhSign: begin
          if ((phase_q != PhSign) && is_white(char_i)) begin
            b_phase = PhSpace;
          end else if ((phase_q != PhSign) && is_sign(char_i)) begin
            b_neg   = (char_i == ChMinus);
            b_phase = PhSign;
          end else if (char_i == ChZero) begin
            b_phase = PhZero;
          end else if (hex_ok) begin
            b_value = {13'd0, hex_v};
            b_phase = PhHex;
          end else begin
            b_part.fail = 1'b1;
          end
        end
        PhZero: begin
          if ((char_i == ChLowX) || (char_i == ChUpX)) begin
            b_phase = PhPrefix;
          end else if (hex_ok) begin
            b_value = {13'd0, hex_v};
            b_phase = PhHex;
          end else begin
            b_part.fail = 1'b1;
          end
        end
        PhPrefix: begin
          if (hex_ok) begin
            b_value = {13'd0, hex_v};
            b_phase = PhHex;
          end else begin
            b_part.fail = 1'b1;
          end
        end
        PhHex: begin
          if (hex_ok) begin
            b_value = (hex_acc > {4'd0, MaxValue}) ? SatValue : hex_acc[16:0];
          end else begin
            b_part.fail = 1'b1;
          end
        end
        default: begin
          b_part.fail = 1'b1;
        end
      endcase
    end
  end

  // Close the final part unless the string ends on a colon, then count parts
  always_comb begin
    e_part = b_part;
    if (char_i != ChColon) begin
      e_part = end_part(b_part, b_phase, b_neg, b_value);
    end
    f_fail = e_part.fail || (!e_part.gap && (e_part.parts != FullParts));
  end

  assign ok_o = !f_fail;

  // Advance on each byte, clear after the final one
  always_comb begin
    count_d = count_q;
    prev_d  = prev_q;
    fail_d  = fail_q;
    gap_d   = gap_q;
    parts_d = parts_q;
    phase_d = phase_q;
    value_d = value_q;
    neg_d   = neg_q;
    if (step_i && last_i) begin
      count_d = '0;
      prev_d  = ChNul;
      fail_d  = 1'b0;
      gap_d   = 1'b0;
      parts_d = '0;
      phase_d = PhEmpty;
      value_d = '0;
      neg_d   = 1'b0;
    end else if (step_i) begin
      count_d = (count_q == 2'd3) ? count_q : count_q + 2'd1;
      prev_d  = char_i;
      fail_d  = b_part.fail;
      gap_d   = b_part.gap;
      parts_d = b_part.parts;
      phase_d = b_phase;
      value_d = b_value;
      neg_d   = b_neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      prev_q  <= ChNul;
      fail_q  <= 1'b0;
      gap_q   <= 1'b0;
      parts_q <= '0;
      phase_q <= PhEmpty;
      value_q <= '0;
      neg_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      prev_q  <= prev_d;
      fail_q  <= fail_d;
      gap_q   <= gap_d;
      parts_q <= parts_d;
      phase_q <= phase_d;
      value_q <= value_d;
      neg_q   <= neg_d;
    end
  end

endmodule

// File: design/ip_address_text_validator_core.sv
// ----------------------------------------------------------------------------
// ip_address_text_validator_core
// Checks address text, one byte per beat, against IPv4 and IPv6 rules and
// returns one result beat on the final byte of each string.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_stall_o   | in_data_i  (ipv_in_t)
//  out     | output    | out_valid_o / out_stall_i | out_data_o (ipv_out_t)
//
//  One byte per cycle sustained while no final byte is held; a result is
//  registered: its final byte waits in the input register, then the parse
//  logic loads the result register.
//  The parse registers in both checkers update once per byte and set the rate.
//  Reset clears both valid flags and all parse state; data registers load on
//  a beat only.
//  Non-final bytes never wait on the output side; a final byte waits in the
//  input register only while a previous result is held by out_stall_i.
module ip_address_text_validator_core import ipv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ipv_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ipv_out_t out_data_o
);

  logic     in_vld_q, in_vld_d;
  ipv_in_t  in_q;
  logic     out_vld_q, out_vld_d;
  ipv_out_t out_q;
  logic     blocked, fire, take, v4_ok, v6_ok;

  // Hold a final byte while the result register is full and stalled
  assign blocked    = in_q.last_char && out_vld_q && out_stall_i;
  assign fire       = in_vld_q && !blocked;
  assign in_stall_o = in_vld_q && blocked;
  assign take       = in_valid_i && !in_stall_o;

  assign in_vld_d  = take || (in_vld_q && !fire);
  assign out_vld_d = (fire && in_q.last_char) || (out_vld_q && out_stall_i);

  ipv_dot_check u_dot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .char_i (in_q.char_code),
    .last_i (in_q.last_char),
    .ok_o   (v4_ok)
  );

  ipv_colon_check u_colon (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .char_i (in_q.char_code),
    .last_i (in_q.last_char),
    .ok_o   (v6_ok)
  );

  // Input register and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= in_data_i;
    end
    if (fire && in_q.last_char) begin
      out_q.is_ipv4 <= v4_ok;
      out_q.is_ipv6 <= v6_ok;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// File: design/ipv_checker.sv
// ----------------------------------------------------------------------------
// ipv_checker
// Port-level checks for the address text validator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv_checker import ipv_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input ipv_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input ipv_out_t out_data_o
);

  // A stalled result beat stays offered
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // A stalled result beat keeps its payload
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o))

  // The input side only stalls behind a held result
  `ASSERT_ALWAYS(a_stall_cause, clk_i, rst_ni, !in_stall_o || (out_valid_o && out_stall_i))

  // No text passes both checks: IPv4 text has no colon, IPv6 text needs one
  `ASSERT_ALWAYS(a_not_both, clk_i, rst_ni, !out_valid_o || !(out_data_o.is_ipv4 && out_data_o.is_ipv6))

endmodule

bind ip_address_text_validator_core ipv_checker u_ipv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams address text into ip_address_text_validator_core one byte per beat.
// A short table of directed strings comes first, then random dotted, colon
// and noise strings. Each result beat is checked in order against the verdict
// of a typed row, or else the one a local IPv4/IPv6 parser model predicts.
// ----------------------------------------------------------------------------
module testbench;
  import ipv_pkg::*;

  // Character codes not found in the package
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChLowX  = 8'h78;

  localparam ipv_out_t ResNone = '{is_ipv4: 1'b0, is_ipv6: 1'b0};
  localparam ipv_out_t ResV4   = '{is_ipv4: 1'b1, is_ipv6: 1'b0};
  localparam ipv_out_t ResV6   = '{is_ipv4: 1'b0, is_ipv6: 1'b1};

  localparam int NoPatch     = -1;
  localparam int NumDirRows  = 25;
  localparam int RandomBytes = 1170;
  localparam int CalmFrom    = 600;
  localparam int CalmTo      = 900;
  localparam int IdlePercent = 23;

  typedef enum logic [1:0] {DecLead, DecSign, DecDigits} dec_stage_e;
  typedef enum logic [2:0] {
    HexEmpty, HexSpace, HexSign, HexZero, HexPrefix, HexDigits
  } hex_stage_e;

  // One directed string; typed rows carry their verdict, others use the model
  typedef struct {
    string      text;
    int         patch_at;
    logic [7:0] patch_byte;
    bit         typed;
    ipv_out_t   verdict;
  } text_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  ipv_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  ipv_out_t out_data_o;

  ip_address_text_validator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  text_row_t text_rows [NumDirRows] = '{
    '{"1.2.3.4",            NoPatch, 8'h00, 1'b1, ResV4},
    '{"255.255.255.255",    NoPatch, 8'h00, 1'b1, ResV4},
    '{"256.1.1.1",          NoPatch, 8'h00, 1'b1, ResNone},
    '{"::",                 NoPatch, 8'h00, 1'b1, ResV6},
    '{"1:2:3:4:5:6:7:8",    NoPatch, 8'h00, 1'b1, ResV6},
    '{"ffff::FFFF",         NoPatch, 8'h00, 1'b1, ResV6},
    '{"0x10000::1",         NoPatch, 8'h00, 1'b1, ResNone},
    '{"1.2.3.4.5",          NoPatch, 8'h00, 1'b1, ResNone},
    '{"1.",                 NoPatch, 8'h00, 1'b1, ResNone},
    '{"7",                  NoPatch, 8'h00, 1'b1, ResV4},
    '{"1::2::3",            NoPatch, 8'h00, 1'b1, ResNone},
    '{"1:2:3:4:5:6:7",      NoPatch, 8'h00, 1'b1, ResNone},
    '{"1.2.3.4",            1,       8'h00, 1'b1, ResNone},
    '{"12",                 0,       8'hFF, 1'b1, ResNone},
    '{"-1::",               NoPatch, 8'h00, 1'b0, ResNone},
    '{" +0x1A::",           NoPatch, 8'h00, 1'b0, ResNone},
    '{"-0",                 NoPatch, 8'h00, 1'b0, ResNone},
    '{"1..2",               NoPatch, 8'h00, 1'b0, ResNone},
    '{":",                  NoPatch, 8'h00, 1'b0, ResNone},
    '{"0x",                 NoPatch, 8'h00, 1'b0, ResNone},
    '{" \t1.\n2.\0133.\0154", NoPatch, 8'h00, 1'b0, ResNone},
    '{"+255.-0.0.0",        NoPatch, 8'h00, 1'b0, ResNone},
    '{"\014-0X1a::",        NoPatch, 8'h00, 1'b0, ResNone},
    '{"0xFFFF::-12345",     NoPatch, 8'h00, 1'b0, ResNone},
    '{"00255.0.0.0",        NoPatch, 8'h00, 1'b0, ResNone}
  };

  ipv_out_t   verdict_q [$];
  logic [7:0] text_q [$];
  int         bytes_sent = 0;
  int         results_seen = 0;
  int         fail_count = 0;

  // Parser model state
  logic [1:0]  seen_cnt;
  logic [7:0]  prior_byte;
  bit          v4_bad;
  logic [2:0]  v4_dots;
  dec_stage_e  v4_stage;
  logic [8:0]  v4_val;
  bit          v4_neg;
  bit          v6_bad;
  bit          v6_gap;
  logic [3:0]  v6_groups;
  hex_stage_e  v6_stage;
  logic [16:0] v6_val;
  bit          v6_neg;

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  // Idle at random, except in one calm stretch of the run
  function automatic bit take_break();
    return !(bytes_sent >= CalmFrom && bytes_sent < CalmTo) &&
           ($urandom_range(99) < IdlePercent);
  endfunction

  task automatic log_mismatch(input string msg);
    $display("MISMATCH result %0d: %s", results_seen, msg);
    fail_count++;
  endtask

  // ---------------- parser model ----------------

  function automatic bit ws_char(input logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  // 0..15 for a hex digit, 16 for anything else
  function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
    if (c >= ChZero && c <= ChNine) return 5'(c - ChZero);
    if (c >= ChLowA && c <= ChLowF) return 5'(c - ChLowA + 8'd10);
    if (c >= ChUpA && c <= ChUpF) return 5'(c - ChUpA + 8'd10);
    return 5'd16;
  endfunction

  function automatic void dec_open();
    v4_stage = DecLead;
    v4_val   = '0;
    v4_neg   = 1'b0;
  endfunction

  function automatic void dec_close();
    if (v4_stage != DecDigits) v4_bad = 1'b1;
    if (v4_neg && v4_val != 0) v4_bad = 1'b1;
    if (v4_val > 9'd255) v4_bad = 1'b1;
  endfunction

  function automatic void dec_take(input logic [7:0] c);
    logic [12:0] acc;
    if (c == ChNul) begin
      v4_bad = 1'b1;
      return;
    end
    if (c == ChDot) begin
      dec_close();
      if (v4_dots >= 3'd3) v4_bad = 1'b1;
      else v4_dots++;
      dec_open();
      return;
    end
    if (c >= ChZero && c <= ChNine) begin
      acc = 13'(v4_val * 10) + 13'(c - ChZero);
      v4_val = (acc > 13'd255) ? 9'd256 : acc[8:0];
      v4_stage = DecDigits;
    end else if (v4_stage == DecLead && ws_char(c)) begin
      // leading white space: stay
    end else if (v4_stage == DecLead && (c == ChPlus || c == ChMinus)) begin
      v4_neg = (c == ChMinus);
      v4_stage = DecSign;
    end else begin
      v4_bad = 1'b1;
    end
  endfunction

  function automatic void hex_open();
    v6_stage = HexEmpty;
    v6_val   = '0;
    v6_neg   = 1'b0;
  endfunction

  function automatic void hex_close();
    if (v6_stage == HexEmpty) begin
      if (v6_gap) v6_bad = 1'b1;
      v6_gap = 1'b1;
    end else if (v6_stage == HexZero || v6_stage == HexDigits) begin
      if (!v6_neg && v6_val > 17'hFFFF) v6_bad = 1'b1;
    end else begin
      v6_bad = 1'b1;
    end
    if (v6_groups < 4'd15) v6_groups++;
  endfunction

  function automatic void hex_take(input logic [7:0] c);
    logic [4:0]  h;
    logic [21:0] acc;
    bit          taken;
    h = hex_digit_value(c);
    taken = 1'b0;
    if (c == ChNul) begin
      v6_bad = 1'b1;
      return;
    end
    if (c == ChColon) begin
      // a leading double colon opens the gap and counts no group
      if (seen_cnt == 2'd1 && prior_byte == ChColon) begin
        v6_gap = 1'b1;
        v6_groups = '0;
      end else begin
        hex_close();
      end
      hex_open();
      return;
    end
    if (v6_stage == HexEmpty || v6_stage == HexSpace) begin
      if (ws_char(c)) begin
        v6_stage = HexSpace;
        taken = 1'b1;
      end else if (c == ChPlus || c == ChMinus) begin
        v6_neg = (c == ChMinus);
        v6_stage = HexSign;
        taken = 1'b1;
      end
    end
    if (!taken) begin
      case (v6_stage)
        HexEmpty, HexSpace, HexSign: begin
          if (c == ChZero) begin
            v6_stage = HexZero;
            taken = 1'b1;
          end else if (h < 5'd16) begin
            v6_val = 17'(h);
            v6_stage = HexDigits;
            taken = 1'b1;
          end
        end
        HexZero: begin
          if (c == ChLowX || c == ChUpX) begin
            v6_stage = HexPrefix;
            taken = 1'b1;
          end else if (h < 5'd16) begin
            v6_val = 17'(h);
            v6_stage = HexDigits;
            taken = 1'b1;
          end
        end
        HexPrefix: begin
          if (h < 5'd16) begin
            v6_val = 17'(h);
            v6_stage = HexDigits;
            taken = 1'b1;
          end
        end
        HexDigits: begin
          if (h < 5'd16) begin
            acc = 22'(v6_val) * 22'd16 + 22'(h);
            v6_val = (acc > 22'hFFFF) ? 17'h10000 : acc[16:0];
            taken = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (!taken) v6_bad = 1'b1;
  endfunction

  function automatic void parser_clear();
    seen_cnt   = '0;
    prior_byte = '0;
    v4_bad     = 1'b0;
    v4_dots    = '0;
    dec_open();
    v6_bad     = 1'b0;
    v6_gap     = 1'b0;
    v6_groups  = '0;
    hex_open();
  endfunction

  // Advance the parser by one byte; a final byte yields the verdict
  function automatic void parse_byte(input logic [7:0] c, input bit last,
                                     output bit done, output ipv_out_t verdict);
    verdict = ResNone;
    done = last;
    if (!last) begin
      dec_take(c);
      hex_take(c);
      prior_byte = c;
      if (seen_cnt < 2'd3) seen_cnt++;
      return;
    end
    if (c == ChDot) begin
      v4_bad = 1'b1;
    end else begin
      dec_take(c);
      dec_close();
    end
    if (seen_cnt == 2'd0) v6_bad = 1'b1;
    if (c == ChColon) begin
      // a trailing colon is only allowed as the second of a pair
      if (prior_byte != ChColon) v6_bad = 1'b1;
      hex_take(c);
    end else begin
      hex_take(c);
      hex_close();
    end
    if (!v6_gap && v6_groups != 4'd8) v6_bad = 1'b1;
    verdict.is_ipv4 = !v4_bad;
    verdict.is_ipv6 = !v6_bad;
    parser_clear();
  endfunction

  // ---------------- text generation ----------------

  // Append one byte to the text under construction
  function automatic void add_byte(input logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick_ws();
    return ($urandom_range(5) == 0) ? ChSpace : ChTab + 8'($urandom_range(4));
  endfunction

  function automatic logic [7:0] pick_noise();
    int r;
    r = $urandom_range(99);
    if (r < 35) return ChZero + 8'($urandom_range(9));
    if (r < 50) return ChDot;
    if (r < 65) return ChColon;
    if (r < 75) return pick_ws();
    if (r < 80) return ($urandom_range(1) != 0) ? ChUpA + 8'($urandom_range(5))
                                                : ChLowX;
    return 8'($urandom_range(255));
  endfunction

  function automatic void gen_dotted();
    int parts;
    parts = ($urandom_range(99) < 80) ? 4 : $urandom_range(1, 5);
    for (int i = 0; i < parts; i++) begin
      if (i > 0) add_byte(ChDot);
      if ($urandom_range(99) < 5) continue;
      if ($urandom_range(99) < 8) add_byte(pick_ws());
      if ($urandom_range(99) < 8) add_byte(($urandom_range(1) != 0) ? ChMinus : ChPlus);
      if ($urandom_range(99) < 10) add_byte(ChZero);
      put_str($sformatf("%0d", ($urandom_range(99) < 80) ? $urandom_range(255)
                                                           : $urandom_range(256, 999)));
    end
  endfunction

  function automatic void put_group();
    string s;
    if ($urandom_range(99) < 5) add_byte(pick_ws());
    if ($urandom_range(99) < 8)
      add_byte(($urandom_range(99) < 70) ? ChMinus : ChPlus);
    if ($urandom_range(99) < 15) begin
      add_byte(ChZero);
      add_byte(($urandom_range(1) != 0) ? ChUpX : ChLowX);
    end
    if ($urandom_range(99) < 10) add_byte(ChZero);
    s = $sformatf("%0h", ($urandom_range(99) < 85) ? $urandom_range(16'hFFFF)
                                                     : $urandom_range(20'h10000, 20'hFFFFF));
    // mix the case of the hex letters
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] >= ChLowA && s[i] <= ChLowF && $urandom_range(1) != 0)
        add_byte(8'(s[i]) - 8'h20);
      else
        add_byte(s[i]);
    end
  endfunction

  function automatic void gen_colon();
    int groups;
    int gap_at;
    groups = ($urandom_range(99) < 70) ? 8 : $urandom_range(9);
    gap_at = (groups == 8 && $urandom_range(99) < 75) ? -1 : $urandom_range(groups);
    for (int i = 0; i < groups; i++) begin
      if (i == gap_at) put_str("::");
      else if (i > 0) add_byte(ChColon);
      put_group();
    end
    if (gap_at == groups) put_str("::");
  endfunction

  function automatic void gen_noise();
    int n;
    n = $urandom_range(1, 10);
    repeat (n) add_byte(pick_noise());
  endfunction

  // ---------------- driving ----------------

  // Offer one byte and hold it until the beat is taken
  task automatic send_byte(input logic [7:0] c, input bit last, input bit typed,
                           input ipv_out_t verdict);
    bit       done;
    ipv_out_t model_verdict;
    while (take_break()) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = '{char_code: c, last_char: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    parse_byte(c, last, done, model_verdict);
    if (done) verdict_q.insert(verdict_q.size(), typed ? verdict : model_verdict);
    @(negedge clk_i);
  endtask

  task automatic send_text(input bit typed, input ipv_out_t verdict);
    for (int i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], i == text_q.size() - 1, typed, verdict);
  endtask

  // Receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= take_break();
  end

  // Check each result beat against the oldest verdict
  always @(posedge clk_i) begin : check_results
    ipv_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        log_mismatch($sformatf("unexpected result beat %b", out_data_o));
      end else begin
        want = verdict_q.pop_front();
        if (out_data_o.is_ipv4 !== want.is_ipv4)
          log_mismatch($sformatf("is_ipv4 got %b want %b", out_data_o.is_ipv4, want.is_ipv4));
        if (out_data_o.is_ipv6 !== want.is_ipv6)
          log_mismatch($sformatf("is_ipv6 got %b want %b", out_data_o.is_ipv6, want.is_ipv6));
      end
      results_seen++;
    end
  end

  // Stimulus
  initial begin : stimulus
    int target;
    int drain;
    int pick;
    parser_clear();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed strings
    foreach (text_rows[r]) begin
      text_q.delete();
      put_str(text_rows[r].text);
      if (text_rows[r].patch_at != NoPatch)
        text_q[text_rows[r].patch_at] = text_rows[r].patch_byte;
      send_text(text_rows[r].typed, text_rows[r].verdict);
    end

    // random strings, mostly well formed
    target = bytes_sent + RandomBytes;
    while (bytes_sent < target) begin
      text_q.delete();
      pick = $urandom_range(99);
      if (pick < 40) gen_dotted();
      else if (pick < 80) gen_colon();
      else gen_noise();
      if (pick < 80 && text_q.size() > 0 && $urandom_range(99) < 15)
        text_q[$urandom_range(text_q.size() - 1)] = pick_noise();
      send_text(1'b0, ResNone);
    end
    in_valid_i = 1'b0;

    // drain outstanding results
    drain = 0;
    while (verdict_q.size() > 0 && drain < 5000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (10) @(posedge clk_i);
    if (verdict_q.size() > 0)
      log_mismatch($sformatf("%0d results never arrived", verdict_q.size()));

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/ipv_pkg.sv
design/ipv_dot_check.sv
design/ipv_colon_check.sv
design/ip_address_text_validator_core.sv
design/ipv_checker.sv
sim/testbench.sv
